@@ hdl/pdpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpw_pkg
// Shared types and constants of the polar density point weighting block.
// ----------------------------------------------------------------------------
package pdpw_pkg;

   // angle arithmetic, turns scaled by 2^32
   localparam int CORDIC_STEPS = 24;
   localparam int ZW           = 34;
   localparam int PW           = 33;
   localparam int SCALE_SHIFT  = 20;
   localparam int WEIGHT_SHIFT = 16;

   localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ZW:0]   HALF_TURN    = 35'sd2147483648;
   localparam logic signed [ZW:0]   FULL_TURN    = 35'sd4294967296;

   // depth of the queue between front and back
   localparam int QDEPTH = 4;

   // configuration register indexes
   localparam logic CSR_RING_COUNT   = 1'b0;
   localparam logic CSR_SECTOR_COUNT = 1'b1;

   // classified point entry, front to back
   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        keep;
      logic        final_point;
   } pdpw_item_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_RHS,
      ST_FETCH,
      ST_ITER,
      ST_SECT,
      ST_COUNT,
      ST_WFETCH,
      ST_WBIN,
      ST_WDEN,
      ST_DIV,
      ST_WOUT
   } pdpw_state_type;

   // arctangent of 2^-i in turns scaled by 2^32
   function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] step);
      logic signed [ZW-1:0] val;
      case (step)
         5'd0:    val = 34'sd536870912;
         5'd1:    val = 34'sd316933406;
         5'd2:    val = 34'sd167458907;
         5'd3:    val = 34'sd85004756;
         5'd4:    val = 34'sd42667331;
         5'd5:    val = 34'sd21354465;
         5'd6:    val = 34'sd10679838;
         5'd7:    val = 34'sd5340245;
         5'd8:    val = 34'sd2670163;
         5'd9:    val = 34'sd1335087;
         5'd10:   val = 34'sd667544;
         5'd11:   val = 34'sd333772;
         5'd12:   val = 34'sd166886;
         5'd13:   val = 34'sd83443;
         5'd14:   val = 34'sd41722;
         5'd15:   val = 34'sd20861;
         5'd16:   val = 34'sd10430;
         5'd17:   val = 34'sd5215;
         5'd18:   val = 34'sd2608;
         5'd19:   val = 34'sd1304;
         5'd20:   val = 34'sd652;
         5'd21:   val = 34'sd326;
         5'd22:   val = 34'sd163;
         5'd23:   val = 34'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/pdpw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpw_front
// Accepts points, marks those that still fit the store, queues them.
// ----------------------------------------------------------------------------
module pdpw_front import pdpw_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic [15:0]   req_pos_x,
   input  logic [15:0]   req_pos_y,
   input  logic          req_final_point,
   output logic          item_valid,
   output pdpw_item_type item,
   input  logic          item_pop
);

   localparam int NW  = $clog2(MAX_POINTS + 1);
   localparam int QPW = $clog2(QDEPTH);

   logic [NW-1:0]  loaded_ff;
   logic [QPW-1:0] head_ff, tail_ff;
   logic [QPW:0]   count_ff;
   pdpw_item_type  q_ff [QDEPTH];
   logic           push_ok, pop_ok, keep;

   assign req_full   = (count_ff == (QPW+1)'(QDEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[head_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;
   assign keep       = (int'(loaded_ff) < MAX_POINTS);

   // points of the open set, decides which ones still fit
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (push_ok) begin
         if (req_final_point) begin
            loaded_ff <= '0;
         end else if (keep) begin
            loaded_ff <= loaded_ff + NW'(1);
         end
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push_ok) tail_ff <= tail_ff + QPW'(1);
         if (pop_ok)  head_ff <= head_ff + QPW'(1);
         if (push_ok && !pop_ok)      count_ff <= count_ff + (QPW+1)'(1);
         else if (!push_ok && pop_ok) count_ff <= count_ff - (QPW+1)'(1);
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[tail_ff] <= '{pos_x: req_pos_x, pos_y: req_pos_y, keep: keep,
                            final_point: req_final_point};
      end
   end

endmodule

@@ hdl/pdpw_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpw_engine
// Stores a set, bins each point around the centroid and divides out weights.
// ----------------------------------------------------------------------------
module pdpw_engine import pdpw_pkg::*; #(
   parameter int MAX_POINTS  = 64,
   parameter int MAX_RINGS   = 10,
   parameter int MAX_SECTORS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_valid,
   input  pdpw_item_type                        item,
   output logic                                 item_pop,
   input  logic [$clog2(MAX_RINGS+1)-1:0]       rings,
   input  logic [$clog2(MAX_SECTORS+1)-1:0]     sectors,
   input  logic                                 out_pop,
   output logic                                 out_empty,
   output logic [5:0]                           out_index,
   output logic [16:0]                          out_weight,
   output logic [3:0]                           out_ring,
   output logic [3:0]                           out_sector,
   output logic                                 out_last
);

   localparam int NW    = $clog2(MAX_POINTS + 1);
   localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SW    = 16 + NW;
   localparam int DW    = SW + 1;
   localparam int D2W   = 2 * DW;
   localparam int RW    = $clog2(MAX_RINGS + 1);
   localparam int AW    = $clog2(MAX_SECTORS + 1);
   localparam int RHW   = D2W + 2 * RW;
   localparam int XW    = DW + SCALE_SHIFT + 2;
   localparam int NBINS = MAX_RINGS * MAX_SECTORS;
   localparam int BW    = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam int BOPW  = BW + RW + AW;
   localparam int TW    = $clog2(MAX_POINTS * (2 * MAX_RINGS - 1) + 1);
   localparam int DENW  = NW + TW;
   localparam int NUMW  = ((RW + 1 + WEIGHT_SHIFT > DENW) ? RW + 1 + WEIGHT_SHIFT : DENW) + 1;
   localparam int CW    = $clog2(((NUMW > CORDIC_STEPS) ? NUMW : CORDIC_STEPS) + 1);

   pdpw_state_type state_ff, state_in;

   // set accumulation
   logic [NW-1:0]  n_ff;
   logic [SW-1:0]  sumx_ff, sumy_ff;
   logic [15:0]    xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic [15:0]    x_mem [MAX_POINTS];
   logic [15:0]    y_mem [MAX_POINTS];
   logic [15:0]    rdx_ff, rdy_ff;

   // per point datapath
   logic [IW-1:0]          idx_ff;
   logic [1:0]             corner_ff;
   logic                   phase_ff;
   logic signed [DW-1:0]   dx_ff, dy_ff;
   logic [D2W-1:0]         sqx_ff, d2_ff, m2_ff;
   logic [RHW-1:0]         rhs_ff, acc_ff, delta_ff;
   logic [RW-1:0]          ring_ff;
   logic                   rdone_ff;
   logic signed [XW-1:0]   cx_ff, cy_ff;
   logic signed [ZW-1:0]   z_ff;
   logic [CW-1:0]          step_ff;
   logic                   zero_ff;
   logic [BW-1:0]          bin_ff;
   logic [AW-1:0]          sec_ff;

   // bins and weights
   logic [BOPW-1:0]  bop_mem [MAX_POINTS];
   logic [BOPW-1:0]  bop_rd_ff;
   logic [NW-1:0]    bin_mem [NBINS];
   logic [NW-1:0]    bin_rd_ff;
   logic [NBINS-1:0] bin_vld_ff;
   logic [TW-1:0]    stot_ff;
   logic [DENW-1:0]  den_ff;
   logic [DENW-1:0]  rem_ff;
   logic [NUMW-1:0]  quo_ff;

   // result register
   logic        out_valid_ff;
   logic [5:0]  oidx_ff;
   logic [16:0] owt_ff;
   logic [3:0]  oring_ff, osec_ff;
   logic        olast_ff;

   // combinational helpers
   logic                  load_go, corner_last, last_point, cordic_done, out_free;
   logic [15:0]           srcx, srcy;
   logic [SW-1:0]         nx, ny;
   logic signed [DW-1:0]  dx_c, dy_c;
   logic signed [D2W-1:0] psq;
   logic [2*RW-1:0]       rr;
   logic signed [XW-1:0]  xs0, ys0, xsh, ysh;
   logic signed [ZW:0]    pz;
   logic [PW-1:0]         pval;
   logic [PW+AW-1:0]      pprod;
   logic [AW:0]           sraw;
   logic [AW-1:0]         sec_c;
   logic [BW-1:0]         bin_c, bin_raddr;
   logic [BW-1:0]         bop_bin;
   logic [RW-1:0]         bop_ring;
   logic [AW-1:0]         bop_sec;
   logic [NW-1:0]         cnt_c;
   logic [DENW-1:0]       den_c;
   logic [DENW:0]         trial;

   assign load_go     = (state_ff == ST_LOAD) && item_valid;
   assign corner_last = (corner_ff == 2'd3);
   assign last_point  = ((NW'(idx_ff) + NW'(1)) == n_ff);
   assign cordic_done = (step_ff == CW'(CORDIC_STEPS)) && rdone_ff;
   assign out_free    = !out_valid_ff || out_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:   if (load_go && item.final_point) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQX;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_RHS;
         ST_RHS: begin
            if (phase_ff)         state_in = ST_ITER;
            else if (corner_last) state_in = ST_FETCH;
            else                  state_in = ST_DIFF;
         end
         ST_FETCH:  state_in = ST_DIFF;
         ST_ITER:   if (cordic_done) state_in = ST_SECT;
         ST_SECT:   state_in = ST_COUNT;
         ST_COUNT:  state_in = last_point ? ST_WFETCH : ST_FETCH;
         ST_WFETCH: state_in = ST_WBIN;
         ST_WBIN:   state_in = ST_WDEN;
         ST_WDEN:   state_in = ST_DIV;
         ST_DIV:    if (step_ff == CW'(NUMW - 1)) state_in = ST_WOUT;
         ST_WOUT: begin
            if (out_free) state_in = last_point ? ST_LOAD : ST_WFETCH;
         end
         default:   state_in = ST_LOAD;
      endcase
   end

   // state outputs
   always_comb begin
      item_pop = (state_ff == ST_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

   // offsets from the centroid, scaled by n
   always_comb begin
      srcx = phase_ff ? rdx_ff : (corner_ff[0] ? xmax_ff : xmin_ff);
      srcy = phase_ff ? rdy_ff : (corner_ff[1] ? ymax_ff : ymin_ff);
      nx   = SW'(n_ff * srcx);
      ny   = SW'(n_ff * srcy);
      dx_c = $signed({1'b0, nx}) - $signed({1'b0, sumx_ff});
      dy_c = $signed({1'b0, ny}) - $signed({1'b0, sumy_ff});
      psq  = (state_ff == ST_SQX) ? dx_ff * dx_ff : dy_ff * dy_ff;
      rr   = rings * rings;
      xs0  = XW'(dx_ff) <<< SCALE_SHIFT;
      ys0  = XW'(dy_ff) <<< SCALE_SHIFT;
      xsh  = cx_ff >>> step_ff;
      ysh  = cy_ff >>> step_ff;
   end

   // angle to sector and bin address
   always_comb begin
      pz = zero_ff ? HALF_TURN : ($signed({z_ff[ZW-1], z_ff}) + HALF_TURN);
      if (pz < 0)              pval = '0;
      else if (pz > FULL_TURN) pval = FULL_TURN[PW-1:0];
      else                     pval = pz[PW-1:0];
      pprod = pval * sectors;
      sraw  = pprod[PW+AW-1:PW-1];
      sec_c = (sraw >= {1'b0, sectors}) ? sectors - AW'(1) : sraw[AW-1:0];
      bin_c = BW'(ring_ff * MAX_SECTORS) + BW'(sec_c);
      bop_bin   = bop_rd_ff[BOPW-1 -: BW];
      bop_ring  = bop_rd_ff[AW+RW-1 -: RW];
      bop_sec   = bop_rd_ff[AW-1:0];
      bin_raddr = (state_ff == ST_SECT) ? bin_c : bop_bin;
      cnt_c     = bin_vld_ff[bin_ff] ? bin_rd_ff : '0;
      den_c     = bin_rd_ff * stot_ff;
      trial     = {rem_ff, quo_ff[NUMW-1]};
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (load_go && item.keep) begin
         x_mem[n_ff[IW-1:0]] <= item.pos_x;
         y_mem[n_ff[IW-1:0]] <= item.pos_y;
      end
      rdx_ff <= x_mem[idx_ff];
      rdy_ff <= y_mem[idx_ff];
      if (state_ff == ST_SECT) bop_mem[idx_ff] <= {bin_c, ring_ff, sec_c};
      bop_rd_ff <= bop_mem[idx_ff];
      if (state_ff == ST_COUNT) bin_mem[bin_ff] <= cnt_c + NW'(1);
      bin_rd_ff <= bin_mem[bin_raddr];
   end

   // set state, cleared after each closed set
   always_ff @(posedge clock) begin
      if (reset || (state_ff == ST_WOUT && out_free && last_point)) begin
         n_ff       <= '0;
         sumx_ff    <= '0;
         sumy_ff    <= '0;
         xmin_ff    <= 16'hFFFF;
         xmax_ff    <= '0;
         ymin_ff    <= 16'hFFFF;
         ymax_ff    <= '0;
         m2_ff      <= '0;
         stot_ff    <= '0;
         bin_vld_ff <= '0;
      end else begin
         if (load_go && item.keep) begin
            n_ff    <= n_ff + NW'(1);
            sumx_ff <= sumx_ff + SW'(item.pos_x);
            sumy_ff <= sumy_ff + SW'(item.pos_y);
            if (item.pos_x < xmin_ff) xmin_ff <= item.pos_x;
            if (item.pos_x > xmax_ff) xmax_ff <= item.pos_x;
            if (item.pos_y < ymin_ff) ymin_ff <= item.pos_y;
            if (item.pos_y > ymax_ff) ymax_ff <= item.pos_y;
         end
         if (state_ff == ST_RHS && !phase_ff && d2_ff > m2_ff) m2_ff <= d2_ff;
         if (state_ff == ST_COUNT && !bin_vld_ff[bin_ff]) begin
            bin_vld_ff[bin_ff] <= 1'b1;
            stot_ff            <= stot_ff + TW'({ring_ff, 1'b1});
         end
      end
   end

   // per point datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            corner_ff <= '0;
            phase_ff  <= 1'b0;
            idx_ff    <= '0;
         end
         ST_DIFF: begin
            dx_ff <= dx_c;
            dy_ff <= dy_c;
         end
         ST_SQX: sqx_ff <= D2W'(psq);
         ST_SQY: d2_ff <= sqx_ff + D2W'(psq);
         ST_RHS: begin
            if (!phase_ff) begin
               corner_ff <= corner_ff + 2'd1;
               if (corner_last) phase_ff <= 1'b1;
            end
            rhs_ff   <= rr * d2_ff;
            ring_ff  <= '0;
            acc_ff   <= RHW'(m2_ff);
            delta_ff <= RHW'(m2_ff) + (RHW'(m2_ff) << 1);
            rdone_ff <= (m2_ff == '0);
            step_ff  <= '0;
            zero_ff  <= (dx_ff == '0) && (dy_ff == '0);
            // quarter-turn pre-rotation into the right half plane
            if (dx_ff < 0) begin
               if (dy_ff >= 0) begin
                  cx_ff <= ys0;
                  cy_ff <= -xs0;
                  z_ff  <= QUARTER_TURN;
               end else begin
                  cx_ff <= -ys0;
                  cy_ff <= xs0;
                  z_ff  <= -QUARTER_TURN;
               end
            end else begin
               cx_ff <= xs0;
               cy_ff <= ys0;
               z_ff  <= '0;
            end
         end
         ST_ITER: begin
            // cordic vectoring, one micro-rotation a cycle
            if (step_ff < CW'(CORDIC_STEPS)) begin
               step_ff <= step_ff + CW'(1);
               if (cy_ff < 0) begin
                  cx_ff <= cx_ff - ysh;
                  cy_ff <= cy_ff + xsh;
                  z_ff  <= z_ff - atan_turn(5'(step_ff));
               end else begin
                  cx_ff <= cx_ff + ysh;
                  cy_ff <= cy_ff - xsh;
                  z_ff  <= z_ff + atan_turn(5'(step_ff));
               end
            end
            // ring search, (k+1)^2 * m2 kept by running sums
            if (!rdone_ff) begin
               if ((RW'(ring_ff + RW'(1)) < rings) && (acc_ff <= rhs_ff)) begin
                  ring_ff  <= ring_ff + RW'(1);
                  acc_ff   <= acc_ff + delta_ff;
                  delta_ff <= delta_ff + (RHW'(m2_ff) << 1);
               end else begin
                  rdone_ff <= 1'b1;
               end
            end
         end
         ST_SECT: begin
            bin_ff <= bin_c;
            sec_ff <= sec_c;
         end
         ST_COUNT: idx_ff <= last_point ? '0 : idx_ff + IW'(1);
         ST_WBIN: begin
            bin_ff  <= bop_bin;
            ring_ff <= bop_ring;
            sec_ff  <= bop_sec;
         end
         ST_WDEN: begin
            den_ff  <= den_c;
            quo_ff  <= NUMW'({ring_ff, 1'b1, 16'b0}) + NUMW'(den_c >> 1);
            rem_ff  <= '0;
            step_ff <= '0;
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            step_ff <= step_ff + CW'(1);
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= DENW'(trial - {1'b0, den_ff});
               quo_ff <= {quo_ff[NUMW-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DENW-1:0];
               quo_ff <= {quo_ff[NUMW-2:0], 1'b0};
            end
         end
         ST_WOUT: if (out_free && !last_point) idx_ff <= idx_ff + IW'(1);
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == ST_WOUT && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (out_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WOUT && out_free) begin
         oidx_ff  <= 6'(idx_ff);
         owt_ff   <= quo_ff[16:0];
         oring_ff <= 4'(ring_ff);
         osec_ff  <= 4'(sec_ff);
         olast_ff <= last_point;
      end
   end

   assign out_empty  = !out_valid_ff;
   assign out_index  = oidx_ff;
   assign out_weight = owt_ff;
   assign out_ring   = oring_ff;
   assign out_sector = osec_ff;
   assign out_last   = olast_ff;

endmodule

@@ hdl/polar_density_point_weights.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_density_point_weights
// Polar bin density weights for a set of up to MAX_POINTS points.
// ----------------------------------------------------------------------------
// Points come in on the req_ queue, one transfer per cycle while req_full is
// low; req_final_point closes the set. A four-entry queue parts the input
// from the engine, so loading goes on while the engine works or waits.
// Points beyond MAX_POINTS are dropped; the closing item still closes.
// When a set closes, the engine first works through the four box corners,
// then finds the ring and sector of each point, using the shared cordic
// unit, and then the weight of each point in the one-bit-a-cycle weight
// divider, one point of the set at a time through the same datapath.
// Results leave on the rsp_ queue in load order, one per point; rsp_empty
// low means a result is shown, rsp_pop takes it. A stalled receiver holds
// the engine in its output step; nothing is lost. Reset empties both sides,
// clears the set state and sets ring_count to 3 and sector_count to 1.
// csr_ writes belong between sets, while the block is idle.
// ----------------------------------------------------------------------------
module polar_density_point_weights import pdpw_pkg::*; #(
   parameter int MAX_POINTS  = 64,
   parameter int MAX_RINGS   = 10,
   parameter int MAX_SECTORS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic        req_final_point,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_point_index,
   output logic [16:0] rsp_weight,
   output logic [3:0]  rsp_ring,
   output logic [3:0]  rsp_sector,
   output logic        rsp_last_result,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int RW = $clog2(MAX_RINGS + 1);
   localparam int AW = $clog2(MAX_SECTORS + 1);

   logic [3:0]    ring_count_ff;
   logic [4:0]    sector_count_ff;
   logic [RW-1:0] rings;
   logic [AW-1:0] sectors;
   logic          item_valid, item_pop;
   pdpw_item_type item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff   <= 4'd3;
         sector_count_ff <= 5'd1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_RING_COUNT:   ring_count_ff   <= csr_wdata[3:0];
            CSR_SECTOR_COUNT: sector_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the bin counts into the supported range
   always_comb begin
      if (ring_count_ff == '0)                  rings = RW'(1);
      else if (int'(ring_count_ff) > MAX_RINGS) rings = RW'(MAX_RINGS);
      else                                      rings = RW'(ring_count_ff);
      if (sector_count_ff == '0)                    sectors = AW'(1);
      else if (int'(sector_count_ff) > MAX_SECTORS) sectors = AW'(MAX_SECTORS);
      else                                          sectors = AW'(sector_count_ff);
   end

   pdpw_front #(
      .MAX_POINTS(MAX_POINTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_final_point (req_final_point),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   pdpw_engine #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_RINGS   (MAX_RINGS),
      .MAX_SECTORS (MAX_SECTORS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rings      (rings),
      .sectors    (sectors),
      .out_pop    (rsp_pop),
      .out_empty  (rsp_empty),
      .out_index  (rsp_point_index),
      .out_weight (rsp_weight),
      .out_ring   (rsp_ring),
      .out_sector (rsp_sector),
      .out_last   (rsp_last_result)
   );

   // no result is shown right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");

   // a normalized weight never exceeds one
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_weight <= 17'd65536)
      else $error("weight above one");

   // a waiting result is not dropped before its transfer
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result lost");

endmodule

@@ bench/tb_polar_density_point_weights.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_density_point_weights
// Self-checking bench for the polar density point weighting block.
// ----------------------------------------------------------------------------
// Point sets are pushed in with random idling on both sides. A scoreboard
// keeps its own copy of the ring and sector counts and of the open set. When
// a closing point transfer is seen, it bins every point and works out the
// weights in load order. Each result transfer is checked against the oldest
// weight still waiting. Directed sets cover the coordinate extremes, equal
// points, a point on the centroid and an angle of one half turn. Random
// sets follow under several ring and sector settings, some filling the store.
// ----------------------------------------------------------------------------
module tb_polar_density_point_weights;
   import pdpw_pkg::*;

   localparam int NPTS      = 64;
   localparam int NRINGS    = 10;
   localparam int NSECTORS  = 16;
   localparam int WDOG_MAX  = 30000;
   localparam int SETTLE    = 300;

   typedef struct {
      logic [5:0]  idx;
      logic [16:0] weight;
      logic [3:0]  ring;
      logic [3:0]  sector;
      logic        last;
   } point_weight_t;

   // scoreboard: open set, ring/sector counts and weights still due
   class weight_board;
      int unsigned   rings_reg = 3;
      int unsigned   sectors_reg = 1;
      logic [15:0]   set_x[$];
      logic [15:0]   set_y[$];
      point_weight_t due[$];
      int            errors = 0;
      longint        atan_step[24] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772,
         166886, 83443, 41722, 20861, 10430, 5215,
         2608, 1304, 652, 326, 163, 81};

      function void report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      // angle around the centroid plus a half turn, in 2^-32 turn
      function longint angle_turns(longint dx, longint dy);
         longint x, y, z, t, xs, ys;
         z = 0;
         if (dx == 0 && dy == 0) return 64'sd2147483648;
         x = dx * 1048576;
         y = dy * 1048576;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = 1073741824;
            end else begin
               t = x; x = -y; y = t; z = -1073741824;
            end
         end
         for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
               x -= ys; y += xs; z -= atan_step[i];
            end else begin
               x += ys; y -= xs; z += atan_step[i];
            end
         end
         z += 64'sd2147483648;
         if (z < 0) z = 0;
         if (z > 64'sd4294967296) z = 64'sd4294967296;
         return z;
      endfunction

      function void note_point(logic [15:0] px, logic [15:0] py, logic fin);
         longint n, sx, sy, m2, d, dx, dy, rhs, sec, den, num;
         longint xmin, xmax, ymin, ymax;
         int unsigned nr, ns, r, s_total, bin;
         int unsigned cnt[NRINGS*NSECTORS];
         int unsigned bin_of[$];
         point_weight_t e;
         if (set_x.size() < NPTS) begin
            set_x.push_back(px);
            set_y.push_back(py);
         end
         if (!fin) return;
         n = set_x.size();
         nr = rings_reg == 0 ? 1 : (rings_reg > NRINGS ? NRINGS : rings_reg);
         ns = sectors_reg == 0 ? 1 : (sectors_reg > NSECTORS ? NSECTORS : sectors_reg);
         sx = 0; sy = 0; xmin = 65535; xmax = 0; ymin = 65535; ymax = 0;
         foreach (set_x[i]) begin
            sx += set_x[i]; sy += set_y[i];
            if (set_x[i] < xmin) xmin = set_x[i];
            if (set_x[i] > xmax) xmax = set_x[i];
            if (set_y[i] < ymin) ymin = set_y[i];
            if (set_y[i] > ymax) ymax = set_y[i];
         end
         // farthest box corner, scaled by n
         m2 = 0;
         for (int c = 0; c < 4; c++) begin
            dx = n * (c[0] ? xmax : xmin) - sx;
            dy = n * (c[1] ? ymax : ymin) - sy;
            d = dx * dx + dy * dy;
            if (d > m2) m2 = d;
         end
         foreach (cnt[i]) cnt[i] = 0;
         s_total = 0;
         foreach (set_x[i]) begin
            dx = n * set_x[i] - sx;
            dy = n * set_y[i] - sy;
            rhs = longint'(nr) * nr * (dx * dx + dy * dy);
            r = 0;
            if (m2 != 0)
               while (r + 1 < nr && longint'(r + 1) * (r + 1) * m2 <= rhs) r++;
            sec = (angle_turns(dx, dy) * ns) >>> 32;
            if (sec >= ns) sec = ns - 1;
            bin = r * NSECTORS + int'(sec);
            bin_of.push_back(bin);
            if (cnt[bin] == 0) s_total += 2 * r + 1;
            cnt[bin]++;
         end
         foreach (bin_of[i]) begin
            r = bin_of[i] / NSECTORS;
            den = longint'(cnt[bin_of[i]]) * s_total;
            num = longint'(2 * r + 1) * 65536 + den / 2;
            e.idx = i[5:0];
            e.weight = den != 0 ? 17'(num / den) : '0;
            e.ring = r[3:0];
            e.sector = 4'(bin_of[i] % NSECTORS);
            e.last = (i + 1 == n);
            due.push_back(e);
         end
         set_x.delete();
         set_y.delete();
      endfunction

      function void check_result(point_weight_t got);
         point_weight_t exp_w;
         if (due.size() == 0) begin
            report($sformatf("unexpected result for point %0d", got.idx));
            return;
         end
         exp_w = due.pop_front();
         if (got.idx !== exp_w.idx)
            report($sformatf("point_index %0d, want %0d", got.idx, exp_w.idx));
         if (got.weight !== exp_w.weight)
            report($sformatf("point %0d weight %0d, want %0d",
                             exp_w.idx, got.weight, exp_w.weight));
         if (got.ring !== exp_w.ring)
            report($sformatf("point %0d ring %0d, want %0d",
                             exp_w.idx, got.ring, exp_w.ring));
         if (got.sector !== exp_w.sector)
            report($sformatf("point %0d sector %0d, want %0d",
                             exp_w.idx, got.sector, exp_w.sector));
         if (got.last !== exp_w.last)
            report($sformatf("point %0d last_result %0b, want %0b",
                             exp_w.idx, got.last, exp_w.last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [15:0] req_pos_x = '0;
   logic [15:0] req_pos_y = '0;
   logic        req_final_point = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [5:0]  rsp_point_index;
   logic [16:0] rsp_weight;
   logic [3:0]  rsp_ring;
   logic [3:0]  rsp_sector;
   logic        rsp_last_result;
   logic        csr_wen = 1'b0;
   logic        csr_index = CSR_RING_COUNT;
   logic [4:0]  csr_wdata = '0;

   weight_board board = new;
   int          send_idle = 0;   // percent of cycles the sender idles
   int          recv_stall = 0;  // percent of cycles the receiver stalls
   int          items_sent = 0;
   int          quiet_cycles = 0;

   polar_density_point_weights dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: pop pattern
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall);
   end

   // monitor both transfers
   always @(posedge clock) begin
      point_weight_t got;
      bit            moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_push && !req_full) begin
            board.note_point(req_pos_x, req_pos_y, req_final_point);
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            got.idx = rsp_point_index;
            got.weight = rsp_weight;
            got.ring = rsp_ring;
            got.sector = rsp_sector;
            got.last = rsp_last_result;
            board.check_result(got);
            moved = 1'b1;
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= WDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                             input logic fin);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle && gap < 20) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_final_point <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain;
      req_push <= 1'b0;
      @(posedge clock);
      while (board.due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [4:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_RING_COUNT) board.rings_reg = val[3:0];
      else board.sectors_reg = val;
   endtask

   task automatic set_counts(input logic [4:0] rings, input logic [4:0] sectors);
      write_reg(CSR_RING_COUNT, rings);
      write_reg(CSR_SECTOR_COUNT, sectors);
   endtask

   // one random set; coordinates full range, clustered, repeated or extreme
   task automatic random_set(input bit wait_empty);
      int size, style;
      logic [15:0] bx, by, px, py;
      if (wait_empty) begin
         req_push <= 1'b0;
         @(posedge clock);
         while (board.due.size() != 0) @(posedge clock);
      end
      size = ($urandom_range(24) == 0) ? $urandom_range(64, 67) : $urandom_range(1, 10);
      style = $urandom_range(3);
      bx = $urandom; by = $urandom;
      for (int i = 0; i < size; i++) begin
         case (style)
            0: begin px = $urandom; py = $urandom; end
            1: begin
               px = bx + $urandom_range(255);
               py = by + $urandom_range(255);
            end
            2: begin
               px = ($urandom_range(3) == 0) ? bx + 16'd1 : bx;
               py = ($urandom_range(3) == 0) ? by - 16'd1 : by;
            end
            default: begin
               px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               py = $urandom_range(1) ? 16'hFFFF : $urandom;
            end
         endcase
         send_point(px, py, i == size - 1);
      end
   endtask

   initial begin
      logic [4:0] ring_set[8] = '{5'd1, 5'd10, 5'd0, 5'd15, 5'd5, 5'd2, 5'd7, 5'd4};
      logic [4:0] sect_set[8] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd8, 5'd3, 5'd12, 5'd20};
      int idle_send[4] = '{0, 72, 0, 6};
      int idle_recv[4] = '{0, 0, 72, 6};
      int quota;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets under the reset counts, then with more bins
      send_point(16'h0000, 16'h0000, 1'b1);
      send_point(16'hFFFF, 16'hFFFF, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b1);
      drain();
      set_counts(5'd4, 5'd8);
      send_point(16'd0, 16'd100, 1'b0);
      send_point(16'd200, 16'd100, 1'b1);
      send_point(16'h0000, 16'h0000, 1'b0);
      send_point(16'hFFFF, 16'h0000, 1'b0);
      send_point(16'h0000, 16'hFFFF, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b0);
      send_point(16'h8000, 16'h8000, 1'b1);
      send_point(16'h1234, 16'h0000, 1'b0);
      send_point(16'h0000, 16'hABCD, 1'b0);
      send_point(16'h5555, 16'hAAAA, 1'b1);
      send_point(16'h7000, 16'h7000, 1'b1);
      drain();

      // random phases: each setting with one idling pattern
      for (int p = 0; p < 8; p++) begin
         set_counts(ring_set[p], sect_set[p]);
         send_idle = idle_send[p % 4];
         recv_stall = idle_recv[p % 4];
         quota = items_sent + 52;
         if (p == 2) quota = items_sent + 30;
         while (items_sent < quota) random_set(p == 2);
         drain();
      end

      send_idle = 0;
      recv_stall = 0;
      if (board.due.size() != 0)
         board.report($sformatf("%0d results never came", board.due.size()));
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/pdpw_pkg.sv
hdl/pdpw_front.sv
hdl/pdpw_engine.sv
hdl/polar_density_point_weights.sv
bench/tb_polar_density_point_weights.sv
